// ----- src/wsd_pkg.sv -----
package wsd_pkg;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ACT_TEXT    = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_PONG    = 2'd2,
        ACT_DISCARD = 2'd3
    } t_action;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        t_action    action;
        logic       last_byte;
        logic       empty_frame;
        logic       session_closing;
    } t_result;

    function automatic t_action action_of(input logic [3:0] op);
        t_action act;
        case (op)
            OP_TEXT:  act = ACT_TEXT;
            OP_CLOSE: act = ACT_CLOSE;
            OP_PING:  act = ACT_PONG;
            default:  act = ACT_DISCARD;
        endcase
        return act;
    endfunction

endpackage

// ----- src/wsd_parser.sv -----
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_link_error,
    output logic       o_push,
    output t_result    o_result
);

    t_phase      r_phase,      n_phase;
    logic [3:0]  r_opcode,     n_opcode;
    logic        r_mask,       n_mask;
    logic [63:0] r_remaining,  n_remaining;
    logic [2:0]  r_hdr_count,  n_hdr_count;
    logic [31:0] r_key,        n_key;
    logic [1:0]  r_mask_index, n_mask_index;
    logic        r_closed,     n_closed;

    logic        len_known;
    logic        enter;
    logic [2:0]  count_inc;
    logic [7:0]  key_byte;
    logic [63:0] rem_dec;
    logic        is_close;

    assign count_inc = r_hdr_count + 3'd1;
    assign rem_dec   = r_remaining - 64'd1;
    assign is_close  = (r_opcode == OP_CLOSE);

    always_comb begin
        case (r_mask_index)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_opcode     = r_opcode;
        n_mask       = r_mask;
        n_remaining  = r_remaining;
        n_hdr_count  = r_hdr_count;
        n_key        = r_key;
        n_mask_index = r_mask_index;
        n_closed     = r_closed;
        len_known    = 1'b0;
        enter        = 1'b0;
        o_push       = 1'b0;
        o_result     = '{payload_byte: 8'd0, frame_opcode: r_opcode,
                         action: action_of(r_opcode), last_byte: 1'b0,
                         empty_frame: 1'b0, session_closing: 1'b0};

        if (i_accept && !r_closed) begin
            if (i_link_error) begin
                n_phase      = PH_HDR0;
                n_opcode     = 4'd0;
                n_mask       = 1'b0;
                n_remaining  = 64'd0;
                n_hdr_count  = 3'd0;
                n_key        = 32'd0;
                n_mask_index = 2'd0;
                n_closed     = 1'b1;
                o_push       = 1'b1;
                o_result     = '{payload_byte: 8'd0, frame_opcode: 4'd0,
                                 action: ACT_DISCARD, last_byte: 1'b0,
                                 empty_frame: 1'b0, session_closing: 1'b1};
            end else begin
                case (r_phase)
                    PH_HDR0: begin
                        n_opcode = i_byte[3:0];
                        n_phase  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_mask      = i_byte[7];
                        n_hdr_count = 3'd0;
                        n_remaining = 64'd0;
                        if (i_byte[6:0] == LEN_EXT16) begin
                            n_phase = PH_EXT16;
                        end else if (i_byte[6:0] == LEN_EXT64) begin
                            n_phase = PH_EXT64;
                        end else begin
                            n_remaining = {57'd0, i_byte[6:0]};
                            len_known   = 1'b1;
                        end
                    end
                    PH_EXT16, PH_EXT64: begin
                        n_remaining = {r_remaining[55:0], i_byte};
                        n_hdr_count = count_inc;
                        if ((r_phase == PH_EXT16) ? (count_inc == 3'd2)
                                                  : (count_inc == 3'd0)) begin
                            len_known = 1'b1;
                        end
                    end
                    PH_MASK: begin
                        n_key       = {r_key[23:0], i_byte};
                        n_hdr_count = count_inc;
                        if (count_inc == 3'd4) begin
                            enter = 1'b1;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_mask_index = r_mask_index + 2'd1;
                        n_remaining  = rem_dec;
                        o_push       = 1'b1;
                        o_result.payload_byte = r_mask ? (i_byte ^ key_byte) : i_byte;
                        if (rem_dec == 64'd0) begin
                            o_result.last_byte       = 1'b1;
                            o_result.session_closing = is_close;
                            n_closed     = r_closed | is_close;
                            n_phase      = PH_HDR0;
                            n_hdr_count  = 3'd0;
                            n_mask_index = 2'd0;
                        end
                    end
                    default: begin
                        n_phase      = PH_HDR0;
                        n_opcode     = 4'd0;
                        n_mask       = 1'b0;
                        n_remaining  = 64'd0;
                        n_hdr_count  = 3'd0;
                        n_key        = 32'd0;
                        n_mask_index = 2'd0;
                    end
                endcase

                // length settled: fetch the mask key or go straight to payload
                if (len_known) begin
                    n_hdr_count = 3'd0;
                    if (n_mask) begin
                        n_phase = PH_MASK;
                        n_key   = 32'd0;
                    end else begin
                        enter = 1'b1;
                    end
                end

                if (enter) begin
                    n_mask_index = 2'd0;
                    n_hdr_count  = 3'd0;
                    if (n_remaining == 64'd0) begin
                        o_push                   = 1'b1;
                        o_result.last_byte       = 1'b1;
                        o_result.empty_frame     = 1'b1;
                        o_result.session_closing = is_close;
                        n_closed = r_closed | is_close;
                        n_phase  = PH_HDR0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR0;
            r_opcode     <= 4'd0;
            r_mask       <= 1'b0;
            r_remaining  <= 64'd0;
            r_hdr_count  <= 3'd0;
            r_key        <= 32'd0;
            r_mask_index <= 2'd0;
            r_closed     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_opcode     <= n_opcode;
            r_mask       <= n_mask;
            r_remaining  <= n_remaining;
            r_hdr_count  <= n_hdr_count;
            r_key        <= n_key;
            r_mask_index <= n_mask_index;
            r_closed     <= n_closed;
        end
    end

endmodule

// ----- src/wsd_out_buf.sv -----
module wsd_out_buf
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    pop;

    assign pop      = r_out_valid & i_ready;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // no push while the skid is occupied
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

// ----- src/websocket_frame_deframer_unit.sv -----
// WebSocket frame deframer.
// Feed the received byte stream, one byte per beat, on the slave channel:
// tdata carries the byte, tuser flags a link error (the byte is then unused).
// Header, extended length and mask key bytes give no result. Each payload
// byte comes out unmasked on the master channel, tagged with the frame
// opcode and an action (deliver text, echo close, answer ping, discard);
// tlast marks the final payload byte. A zero-length frame gives one empty
// result on its last header byte. A close frame or a link error ends the
// session; every later beat is accepted and dropped until reset.
// A result is registered in the output stage before it appears on the master channel.
// Throughput: one beat per cycle while tready is high; the parse and unmask of a beat is a single
// registered step, with the 64-bit length countdown the deepest path.
// A two-entry output stage (result register plus skid) lets a beat enter
// while a result waits; tready drops only when both entries are full.
// Reset (synchronous, active low) empties the output stage, returns the
// parser to the first header byte and reopens the session.
module websocket_frame_deframer_unit
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic       i_s_axis_tuser,   // [0] link_error
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] payload_byte
    output logic [7:0] o_m_axis_tuser,   // [3:0] frame_opcode, [5:4] action,
                                         // [6] empty_frame, [7] session_closing
    output logic       o_m_axis_tlast    // last_byte
);

    logic    accept;
    logic    push;
    logic    full;
    t_result result;
    t_result out_result;

    // take a beat whenever the output stage has room
    assign o_s_axis_tready = ~full;
    assign accept          = i_s_axis_tvalid & ~full;

    wsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_s_axis_tdata),
        .i_link_error (i_s_axis_tuser),
        .o_push       (push),
        .o_result     (result)
    );

    wsd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (full),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = out_result.payload_byte;
    assign o_m_axis_tuser = {out_result.session_closing, out_result.empty_frame,
                             out_result.action, out_result.frame_opcode};
    assign o_m_axis_tlast = out_result.last_byte;

endmodule
